### src/tq_pkg.sv
// ----------------------------------------------------------------------------
// tq_pkg
// Shared codes and controller/datapath handshake types for the ticket queue.
// ----------------------------------------------------------------------------
package tq_pkg;

    localparam logic [1:0] OP_ISSUE   = 2'd0;
    localparam logic [1:0] OP_SERVE   = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;
    localparam logic [1:0] OP_PROMOTE = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_EMPTY       = 2'd1;
    localparam logic [1:0] ST_NOT_WAITING = 2'd2;
    localparam logic [1:0] ST_FULL        = 2'd3;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    typedef struct packed {
        logic load;
        logic exec;
        logic exec2;
        logic put;
    } tq_cmd_t;

    typedef struct packed {
        logic two_step;
        logic out_free;
    } tq_stat_t;

endpackage

### src/tq_ram.sv
// ----------------------------------------------------------------------------
// tq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/tq_ctrl.sv
// ----------------------------------------------------------------------------
// tq_ctrl
// Operation sequencer: accept, execute, optional second link update, output.
// ----------------------------------------------------------------------------
module tq_ctrl
    import tq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  tq_stat_t stat,
    output tq_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_EXEC2 = 2'd2;
    localparam logic [1:0] S_PUT   = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.two_step ? S_EXEC2 : S_PUT;
            end
            S_EXEC2: begin
                cmd.exec2  = 1'b1;
                state_next = S_PUT;
            end
            S_PUT: begin
                cmd.put = stat.out_free;
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_exec_follows_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.exec) else $error("exec did not follow load");
    a_exec2_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec2 |-> $past(cmd.exec)) else $error("exec2 without exec");
    a_put_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.put |-> stat.out_free) else $error("put while output busy");

endmodule

### src/tq_dp.sv
// ----------------------------------------------------------------------------
// tq_dp
// Queue datapath: link, flag and free stack RAMs, head/tail/count registers.
// ----------------------------------------------------------------------------
module tq_dp
    import tq_pkg::*;
#(
    parameter int MAX_IDS = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  tq_cmd_t    cmd,
    output tq_stat_t   stat,
    input  logic [1:0] s_op,
    input  logic [7:0] s_tid,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result_id,
    output logic [1:0] m_status,
    output logic [8:0] m_queue_length
);

    localparam int IDW = $clog2(MAX_IDS);
    localparam int CW  = $clog2(MAX_IDS + 1);

    logic [1:0]     op_reg;
    logic [7:0]     tid_reg;
    logic [IDW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]  count_reg, count_next, issued_reg, issued_next;
    logic [CW-1:0]  top_reg, top_next;
    logic [IDW-1:0] rid_reg, rid_next;
    logic [1:0]     rst_reg, rst_next;
    logic           m_valid_reg;
    logic [7:0]     m_id_reg;
    logic [1:0]     m_st_reg;
    logic [8:0]     m_len_reg;

    logic [IDW+7:0] s_tid_w, tid_w;
    logic [IDW-1:0] s_id, tid_id;
    logic [IDW-1:0] link_raddr, free_raddr;
    logic [IDW-1:0] nx_rd, pv_rd, fr_rd;
    logic           fl_rd;

    logic           nx_we, pv_we, fr_we, fl_we, fl_wd;
    logic [IDW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, fr_wa, fr_wd, fl_wa;

    logic           waiting, x_head, x_tail, tid_range;
    logic [IDW-1:0] x_id, new_id;
    logic           got;
    logic           two_step_c;
    logic           echo_tid;
    logic [IDW+7:0] rid_w;
    logic [CW+8:0]  len_w;

    assign s_tid_w    = (IDW + 8)'(s_tid);
    assign s_id       = s_tid_w[IDW-1:0];
    assign tid_w      = (IDW + 8)'(tid_reg);
    assign tid_id     = tid_w[IDW-1:0];
    assign link_raddr = (s_op == OP_SERVE) ? head_reg : s_id;
    assign free_raddr = IDW'(top_reg - 1'b1);

    tq_ram #(.WIDTH(IDW), .DEPTH(MAX_IDS)) u_next (.aclk(aclk), .we(nx_we),
        .waddr(nx_wa), .wdata(nx_wd), .raddr(link_raddr), .rdata(nx_rd));
    tq_ram #(.WIDTH(IDW), .DEPTH(MAX_IDS)) u_prev (.aclk(aclk), .we(pv_we),
        .waddr(pv_wa), .wdata(pv_wd), .raddr(link_raddr), .rdata(pv_rd));
    tq_ram #(.WIDTH(IDW), .DEPTH(MAX_IDS)) u_free (.aclk(aclk), .we(fr_we),
        .waddr(fr_wa), .wdata(fr_wd), .raddr(free_raddr), .rdata(fr_rd));
    tq_ram #(.WIDTH(1), .DEPTH(MAX_IDS)) u_flag (.aclk(aclk), .we(fl_we),
        .waddr(fl_wa), .wdata(fl_wd), .raddr(link_raddr), .rdata(fl_rd));

    assign tid_range = (32'(tid_reg) < 32'(MAX_IDS)) && (32'(tid_reg) < 32'(issued_reg));
    assign waiting   = tid_range && fl_rd;
    assign x_id      = (op_reg == OP_SERVE) ? head_reg : tid_id;
    assign x_head    = (x_id == head_reg);
    assign x_tail    = (x_id == tail_reg);
    assign echo_tid  = (op_reg == OP_REMOVE) || (op_reg == OP_PROMOTE);

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        issued_next = issued_reg;
        top_next    = top_reg;
        rid_next    = rid_reg;
        rst_next    = rst_reg;
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
        fr_we = 1'b0; fr_wa = '0; fr_wd = '0;
        fl_we = 1'b0; fl_wa = '0; fl_wd = 1'b0;
        got    = 1'b0;
        new_id = '0;
        two_step_c = 1'b0;
        if (cmd.exec) begin
            rid_next = tid_id;
            rst_next = ST_OK;
            case (op_reg)
                OP_ISSUE: begin
                    if (top_reg != '0) begin
                        got      = 1'b1;
                        new_id   = fr_rd;
                        top_next = top_reg - 1'b1;
                    end else if (32'(issued_reg) < 32'(MAX_IDS)) begin
                        got         = 1'b1;
                        new_id      = IDW'(issued_reg);
                        issued_next = issued_reg + 1'b1;
                    end
                    if (got) begin
                        if (count_reg == '0) begin
                            head_next = new_id;
                        end else begin
                            nx_we = 1'b1; nx_wa = tail_reg; nx_wd = new_id;
                            pv_we = 1'b1; pv_wa = new_id;   pv_wd = tail_reg;
                        end
                        tail_next  = new_id;
                        fl_we = 1'b1; fl_wa = new_id; fl_wd = 1'b1;
                        count_next = count_reg + 1'b1;
                        rid_next   = new_id;
                    end else begin
                        rst_next = ST_FULL;
                        rid_next = '0;
                    end
                end
                OP_SERVE, OP_REMOVE: begin
                    if ((op_reg == OP_SERVE) && (count_reg == '0)) begin
                        rst_next = ST_EMPTY;
                        rid_next = '0;
                    end else if ((op_reg == OP_REMOVE) && !waiting) begin
                        rst_next = ST_NOT_WAITING;
                    end else begin
                        rid_next = x_id;
                        if (x_head && x_tail) begin
                            head_next = head_reg;
                        end else if (x_head) begin
                            head_next = nx_rd;
                        end else if (x_tail) begin
                            tail_next = pv_rd;
                        end else begin
                            nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
                            pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
                        end
                        fl_we = 1'b1; fl_wa = x_id; fl_wd = 1'b0;
                        count_next = count_reg - 1'b1;
                        if (32'(top_reg) < 32'(MAX_IDS)) begin
                            fr_we = 1'b1; fr_wa = IDW'(top_reg); fr_wd = x_id;
                            top_next = top_reg + 1'b1;
                        end
                    end
                end
                OP_PROMOTE: begin
                    if (!waiting) begin
                        rst_next = ST_NOT_WAITING;
                    end else if (!x_head) begin
                        two_step_c = 1'b1;
                        if (x_tail) begin
                            tail_next = pv_rd;
                        end else begin
                            nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
                            pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
                        end
                    end
                end
                default: rst_next = ST_OK;
            endcase
        end
        if (cmd.exec2) begin
            nx_we = 1'b1; nx_wa = tid_id;   nx_wd = head_reg;
            pv_we = 1'b1; pv_wa = head_reg; pv_wd = tid_id;
            head_next = tid_id;
        end
    end

    assign stat  = '{two_step: two_step_c, out_free: (!m_valid_reg || m_ready)};
    assign rid_w = (IDW + 8)'(rid_reg);
    assign len_w = (CW + 9)'(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_op;
            tid_reg <= s_tid;
        end
        rid_reg <= rid_next;
        rst_reg <= rst_next;
        if (cmd.put) begin
            m_id_reg  <= echo_tid ? tid_reg : rid_w[7:0];
            m_st_reg  <= rst_reg;
            m_len_reg <= len_w[8:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            issued_reg  <= '0;
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            issued_reg <= issued_next;
            top_reg    <= top_next;
            if (cmd.put) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_id    = m_id_reg;
    assign m_status       = m_st_reg;
    assign m_queue_length = m_len_reg;

    a_ids_conserved: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(top_reg) + 32'(count_reg)) == 32'(issued_reg))
        else $error("issued IDs neither waiting nor free");
    a_full_means_exhausted: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put && rst_reg == ST_FULL) |-> (top_reg == '0 && 32'(issued_reg) == 32'(MAX_IDS)))
        else $error("full reported with IDs left");
    a_empty_means_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put && rst_reg == ST_EMPTY) |-> count_reg == '0)
        else $error("empty reported on nonempty queue");

endmodule

### src/ticket_queue_with_id_recycling.sv
// ----------------------------------------------------------------------------
// ticket_queue_with_id_recycling
// FIFO of ticket IDs as a doubly linked list with a LIFO stack of freed IDs.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata fields (low bit first)
//  s_       | in        | operation[1:0], ticket_id[9:2], zero pad to 16
//  m_       | out       | result_id[7:0], status[9:8], queue_length[18:10], pad to 24
//
//  Each beat passes accept, execute and output steps; promote of a non-head ID
//  adds a second link update step, as that update shares the link RAM write ports.
//  A result waiting in the output register holds the next beat in the output
//  step and blocks further input until it drains.
//  Reset clears head, tail, counters; link, flag and stack RAMs need no clear.
// ----------------------------------------------------------------------------
module ticket_queue_with_id_recycling
    import tq_pkg::*;
#(
    parameter int MAX_IDS = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // operation, ticket_id
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // result_id, status, queue_length
);

    tq_cmd_t    cmd;
    tq_stat_t   stat;
    logic [7:0] rid;
    logic [1:0] st;
    logic [8:0] len;

    tq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    tq_dp #(.MAX_IDS(MAX_IDS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_op(s_tdata[1:0]), .s_tid(s_tdata[9:2]),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_result_id(rid), .m_status(st), .m_queue_length(len)
    );

    assign m_tdata = {5'b0, len, st, rid};

endmodule
